[rtl/icss_pkg.sv]
package icss_pkg;

  localparam int SLOTS_DEF = 128;
  localparam logic [31:0] TIME_WINDOW = 32'd100000000;

  localparam logic [26:0] TIMEOUT_RST = 27'd1000;
  localparam logic [26:0] PAUSE_RST = 27'd50;
  localparam logic [7:0] RETRY_RST = 8'd5;

  // input modes
  localparam logic [2:0] MODE_ALLOC = 3'd0;
  localparam logic [2:0] MODE_TICK = 3'd1;
  localparam logic [2:0] MODE_DONE = 3'd2;
  localparam logic [2:0] MODE_FAIL = 3'd3;
  localparam logic [2:0] MODE_DELAY = 3'd4;

  // result status codes
  localparam logic [3:0] ST_ACCEPTED = 4'd0;
  localparam logic [3:0] ST_FULL = 4'd1;
  localparam logic [3:0] ST_IDLE = 4'd2;
  localparam logic [3:0] ST_ISSUE = 4'd3;
  localparam logic [3:0] ST_DONE = 4'd4;
  localparam logic [3:0] ST_DELAY = 4'd5;
  localparam logic [3:0] ST_RETRY = 4'd6;
  localparam logic [3:0] ST_FAILED = 4'd7;
  localparam logic [3:0] ST_IGNORED = 4'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_PAUSE = 2'd1;
  localparam logic [1:0] CFG_RETRY = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] slot;
    logic [31:0] now_time;
    logic is_write;
    logic has_callback;
    logic has_delay;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [6:0] out_slot;
    logic out_write;
  } out_item_t;

  // per-slot record held in memory (busy kept in flops)
  typedef struct packed {
    logic sent;
    logic waiting;
    logic dir_write;
    logic delayed_notify;
    logic [7:0] errors;
    logic [31:0] deadline;
  } slot_rec_t;

  function automatic logic reached(input logic [31:0] now, input logic [31:0] mark);
    logic [31:0] d;
    begin
      d = now - mark;
      reached = (d < TIME_WINDOW);
    end
  endfunction

endpackage

[rtl/icss_slot_ram.sv]
module icss_slot_ram
  import icss_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  slot_rec_t       wdata,
  input  logic [AW-1:0]   raddr,
  output slot_rec_t       rdata
);

  slot_rec_t mem [SLOTS];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/i2c_command_slot_scheduler_unit.sv]
// Command slot scheduler. Slot records live in a single-port-write,
// registered-read memory; busy bits are flops. Allocate, done, failed and
// delay-expired items show their result after a read, a modify/write and a
// result step. A tick walks every slot through the memory, one slot per
// cycle, before its result shows; no new item is taken until the tick's
// result is out. Results sit in an output register; the next item is
// accepted in the cycle after the current result is taken.
module i2c_command_slot_scheduler_unit
  import icss_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [26:0] cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [26:0] timeout_r;
  logic [26:0] pause_r;
  logic [7:0] retry_r;
  logic [SLOTS-1:0] busy_r;
  logic [31:0] next_issue_r;
  in_item_t item_r;
  out_item_t res_r;
  logic res_valid_r;
  logic [CW-1:0] idx_r;
  logic [AW-1:0] rd_idx_r;
  logic rd_ok_r;
  logic issued_r;
  logic [AW-1:0] islot_r;
  logic iwrite_r;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  slot_rec_t ram_wdata, ram_rdata;

  icss_slot_ram #(.SLOTS(SLOTS), .AW(AW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE) && !res_valid_r;
  assign out_valid = res_valid_r;
  assign out_data = res_r;

  // lowest free slot
  logic free_found;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic slot_in_range;
  assign slot_in_range = ({25'd0, item_r.slot} < 32'(SLOTS));
  logic [AW-1:0] ev_idx;
  assign ev_idx = item_r.slot[AW-1:0];

  // main sequencer
  always_comb begin
    state_nxt = state_r;
    ram_we = 1'b0;
    ram_waddr = ev_idx;
    ram_wdata = ram_rdata;
    ram_raddr = ev_idx;
    // a tick starts reading slot 0 in the read cycle (idx_r is still 0 there)
    if (state_r == S_SCAN || (state_r == S_READ && item_r.mode == MODE_TICK)) begin
      ram_raddr = idx_r[AW-1:0];
    end
    case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = S_READ;
      S_READ: state_nxt = (item_r.mode == MODE_TICK) ? S_SCAN : S_EXEC;
      S_EXEC: begin
        state_nxt = S_OUT;
        if (item_r.mode == MODE_ALLOC) begin
          ram_waddr = free_idx;
          ram_we = free_found;
          ram_wdata.sent = 1'b0;
          ram_wdata.waiting = 1'b0;
          ram_wdata.dir_write = item_r.is_write;
          ram_wdata.delayed_notify = item_r.is_write & item_r.has_callback
                                     & item_r.has_delay;
          ram_wdata.errors = '0;
        end else if (slot_in_range && busy_r[ev_idx]) begin
          if (item_r.mode == MODE_DONE && ram_rdata.sent) begin
            ram_we = ram_rdata.delayed_notify;
            ram_wdata.waiting = 1'b1;
          end else if (item_r.mode == MODE_FAIL && ram_rdata.sent) begin
            ram_we = 1'b1;
            ram_wdata.errors = ram_rdata.errors + 8'd1;
            if (ram_rdata.errors < retry_r) ram_wdata.sent = 1'b0;
          end
        end
      end
      S_SCAN: begin
        // rd_idx_r data is valid in ram_rdata this cycle
        ram_waddr = rd_idx_r;
        if (rd_ok_r && busy_r[rd_idx_r]) begin
          if (ram_rdata.sent) begin
            if (reached(item_r.now_time, ram_rdata.deadline) && !ram_rdata.waiting) begin
              ram_we = 1'b1;
              ram_wdata.sent = 1'b0;
              ram_wdata.errors = ram_rdata.errors + 8'd1;
            end
          end else if (!issued_r && reached(item_r.now_time, next_issue_r)) begin
            ram_we = 1'b1;
            ram_wdata.sent = 1'b1;
            ram_wdata.deadline = item_r.now_time + {5'd0, timeout_r};
          end
        end
        if (rd_ok_r && rd_idx_r == AW'(SLOTS - 1)) state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // scan issue detection
  logic scan_issue;
  assign scan_issue = (state_r == S_SCAN) && rd_ok_r && busy_r[rd_idx_r] &&
                      !ram_rdata.sent && !issued_r &&
                      reached(item_r.now_time, next_issue_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      timeout_r <= TIMEOUT_RST;
      pause_r <= PAUSE_RST;
      retry_r <= RETRY_RST;
      busy_r <= '0;
      next_issue_r <= '0;
      res_valid_r <= 1'b0;
      idx_r <= '0;
      rd_ok_r <= 1'b0;
      issued_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_data;
          CFG_PAUSE: pause_r <= cfg_data;
          CFG_RETRY: retry_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (res_valid_r && out_ready) res_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          item_r <= in_data;
          issued_r <= 1'b0;
          idx_r <= '0;
          rd_ok_r <= 1'b0;
        end
        S_READ: begin
          idx_r <= CW'(1);
          rd_idx_r <= '0;
          rd_ok_r <= 1'b1;
        end
        S_EXEC: begin
          res_r <= '{status: ST_IGNORED, out_slot: 7'd0, out_write: 1'b0};
          if (item_r.mode == MODE_ALLOC) begin
            if (free_found) begin
              busy_r[free_idx] <= 1'b1;
              res_r.status <= ST_ACCEPTED;
              res_r.out_slot <= 7'(free_idx);
            end else begin
              res_r.status <= ST_FULL;
            end
          end else if (slot_in_range && busy_r[ev_idx]) begin
            if (item_r.mode == MODE_DELAY && ram_rdata.waiting) begin
              busy_r[ev_idx] <= 1'b0;
              res_r.status <= ST_DONE;
              res_r.out_slot <= item_r.slot;
            end else if (item_r.mode == MODE_DONE && ram_rdata.sent) begin
              res_r.out_slot <= item_r.slot;
              if (ram_rdata.delayed_notify) begin
                res_r.status <= ST_DELAY;
              end else begin
                busy_r[ev_idx] <= 1'b0;
                res_r.status <= ST_DONE;
              end
            end else if (item_r.mode == MODE_FAIL && ram_rdata.sent) begin
              res_r.out_slot <= item_r.slot;
              if (ram_rdata.errors < retry_r) begin
                res_r.status <= ST_RETRY;
              end else begin
                busy_r[ev_idx] <= 1'b0;
                res_r.status <= ST_FAILED;
              end
            end
          end
        end
        S_SCAN: begin
          rd_idx_r <= idx_r[AW-1:0];
          rd_ok_r <= (idx_r < CW'(SLOTS));
          idx_r <= idx_r + CW'(1);
          if (scan_issue) begin
            issued_r <= 1'b1;
            islot_r <= rd_idx_r;
            iwrite_r <= ram_rdata.dir_write;
            next_issue_r <= item_r.now_time + {5'd0, pause_r};
          end
          if (state_nxt == S_OUT) begin
            if (scan_issue) begin
              res_r <= '{status: ST_ISSUE, out_slot: 7'(rd_idx_r),
                         out_write: ram_rdata.dir_write};
              // catch-up against the pacing mark just set by this issue
              if (reached(item_r.now_time, item_r.now_time + {5'd0, pause_r}))
                next_issue_r <= item_r.now_time;
            end else begin
              if (issued_r)
                res_r <= '{status: ST_ISSUE, out_slot: 7'(islot_r), out_write: iwrite_r};
              else
                res_r <= '{status: ST_IDLE, out_slot: 7'd0, out_write: 1'b0};
              if (reached(item_r.now_time, next_issue_r))
                next_issue_r <= item_r.now_time;
            end
          end
        end
        S_OUT: res_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[rtl/icss_checker.sv]
module icss_checker
  import icss_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_item_t out_data
);

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no item taken while a result waits
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("accept while result pending");

  // status code in range
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_IGNORED)
    else $error("bad status");

  // direction only on issue
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_write |-> out_data.status == ST_ISSUE)
    else $error("write flag outside issue");

endmodule

bind i2c_command_slot_scheduler_unit icss_checker u_icss_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import icss_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int NUM_DIRECTED = 23;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 230;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [26:0] cfg_data;

  i2c_command_slot_scheduler_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow copy of the scheduler state
  bit [26:0] timeout_sh;
  bit [26:0] pause_sh;
  bit [7:0] retry_sh;
  bit slot_busy_sh[NSLOT];
  bit slot_sent_sh[NSLOT];
  bit slot_wait_sh[NSLOT];
  bit slot_wr_sh[NSLOT];
  bit slot_notify_sh[NSLOT];
  bit [7:0] slot_err_sh[NSLOT];
  bit [31:0] slot_dl_sh[NSLOT];
  bit [31:0] next_issue_sh;

  out_item_t pending_status_q[$];
  int err_count;
  int burst_left;
  int gap_max;
  int stall_mode;
  int stall_cnt = 0;
  bit [31:0] bus_time;

  // register settings for the random phases
  bit [26:0] tmo_set[NUM_PHASES] = '{27'd20, 27'd0, 27'd99999999, 27'd300, 27'd5000, 27'd1};
  bit [26:0] pau_set[NUM_PHASES] = '{27'd5, 27'd0, 27'd99999999, 27'd0, 27'd100, 27'd2};
  bit [7:0] rty_set[NUM_PHASES] = '{8'd2, 8'd0, 8'd255, 8'd1, 8'd5, 8'd3};

  typedef struct {
    in_item_t item;
    bit chk;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_tab[NUM_DIRECTED] = '{
    '{'{MODE_TICK, 7'd0, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_IDLE, 7'd0, 1'b0}},
    '{'{MODE_ALLOC, 7'd0, 32'd0, 1'b1, 1'b1, 1'b1}, 1'b1, '{ST_ACCEPTED, 7'd0, 1'b0}},
    '{'{MODE_ALLOC, 7'd0, 32'd0, 1'b0, 1'b1, 1'b1}, 1'b1, '{ST_ACCEPTED, 7'd1, 1'b0}},
    '{'{MODE_DONE, 7'd0, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_IGNORED, 7'd0, 1'b0}},
    '{'{MODE_TICK, 7'd0, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_ISSUE, 7'd0, 1'b1}},
    '{'{MODE_TICK, 7'd0, 32'd10, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_IDLE, 7'd0, 1'b0}},
    '{'{MODE_TICK, 7'd0, 32'd60, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_ISSUE, 7'd1, 1'b0}},
    '{'{MODE_DONE, 7'd0, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_DELAY, 7'd0, 1'b0}},
    '{'{MODE_DELAY, 7'd0, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_DONE, 7'd0, 1'b0}},
    '{'{MODE_DONE, 7'd1, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_DONE, 7'd1, 1'b0}},
    '{'{MODE_DELAY, 7'd1, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_IGNORED, 7'd0, 1'b0}},
    '{'{3'd5, 7'd3, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_IGNORED, 7'd0, 1'b0}},
    '{'{3'd7, 7'd127, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}, 1'b1, '{ST_IGNORED, 7'd0, 1'b0}},
    '{'{MODE_FAIL, 7'd127, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_IGNORED, 7'd0, 1'b0}},
    '{'{MODE_ALLOC, 7'd0, 32'd0, 1'b1, 1'b1, 1'b0}, 1'b1, '{ST_ACCEPTED, 7'd0, 1'b0}},
    '{'{MODE_TICK, 7'd0, 32'd200, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_ISSUE, 7'd0, 1'b1}},
    '{'{MODE_FAIL, 7'd0, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_RETRY, 7'd0, 1'b0}},
    '{'{MODE_TICK, 7'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}, 1'b0, '{ST_IDLE, 7'd0, 1'b0}},
    '{'{MODE_TICK, 7'd0, 32'd1300, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_ISSUE, 7'd0, 1'b1}},
    // deadline passed: slot goes back to unsent, no issue in the same tick
    '{'{MODE_TICK, 7'd0, 32'd3000, 1'b0, 1'b0, 1'b0}, 1'b0, '{ST_IDLE, 7'd0, 1'b0}},
    '{'{MODE_TICK, 7'd0, 32'd3000, 1'b0, 1'b0, 1'b0}, 1'b0, '{ST_IDLE, 7'd0, 1'b0}},
    '{'{MODE_DONE, 7'd0, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_DONE, 7'd0, 1'b0}},
    '{'{MODE_ALLOC, 7'd0, 32'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_ACCEPTED, 7'd0, 1'b0}}
  };

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  function automatic bit has_reached(input bit [31:0] now_t, input bit [31:0] mark);
    bit [31:0] d;
    d = now_t - mark;
    return d < 32'd100000000;
  endfunction

  // computes the status item for one accepted item and updates the shadow state
  function automatic out_item_t next_status(input in_item_t it);
    out_item_t r;
    bit issued;
    int islot;
    int s;
    bit [7:0] prev;
    r = '{ST_IDLE, 7'd0, 1'b0};
    s = it.slot;
    if (it.mode == MODE_ALLOC) begin
      r.status = ST_FULL;
      for (int i = 0; i < NSLOT; i++) begin
        if (!slot_busy_sh[i]) begin
          slot_busy_sh[i] = 1'b1;
          slot_sent_sh[i] = 1'b0;
          slot_wait_sh[i] = 1'b0;
          slot_wr_sh[i] = it.is_write;
          slot_notify_sh[i] = it.is_write & it.has_callback & it.has_delay;
          slot_err_sh[i] = '0;
          r.status = ST_ACCEPTED;
          r.out_slot = 7'(i);
          break;
        end
      end
    end else if (it.mode == MODE_TICK) begin
      issued = 1'b0;
      islot = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_busy_sh[i]) begin
          if (slot_sent_sh[i]) begin
            if (has_reached(it.now_time, slot_dl_sh[i]) && !slot_wait_sh[i]) begin
              slot_sent_sh[i] = 1'b0;
              slot_err_sh[i] = slot_err_sh[i] + 8'd1;
            end
          end else if (!issued && has_reached(it.now_time, next_issue_sh)) begin
            slot_sent_sh[i] = 1'b1;
            slot_dl_sh[i] = it.now_time + 32'(timeout_sh);
            next_issue_sh = it.now_time + 32'(pause_sh);
            issued = 1'b1;
            islot = i;
          end
        end
      end
      if (has_reached(it.now_time, next_issue_sh)) next_issue_sh = it.now_time;
      if (issued) r = '{ST_ISSUE, 7'(islot), slot_wr_sh[islot]};
    end else if (it.mode > MODE_DELAY || s >= NSLOT) begin
      r.status = ST_IGNORED;
    end else if (it.mode == MODE_DELAY) begin
      if (slot_busy_sh[s] && slot_wait_sh[s]) begin
        slot_busy_sh[s] = 1'b0;
        r = '{ST_DONE, it.slot, 1'b0};
      end else begin
        r.status = ST_IGNORED;
      end
    end else if (!slot_busy_sh[s] || !slot_sent_sh[s]) begin
      r.status = ST_IGNORED;
    end else if (it.mode == MODE_DONE) begin
      if (slot_notify_sh[s]) begin
        slot_wait_sh[s] = 1'b1;
        r = '{ST_DELAY, it.slot, 1'b0};
      end else begin
        slot_busy_sh[s] = 1'b0;
        r = '{ST_DONE, it.slot, 1'b0};
      end
    end else begin
      // failed transfer: compare the old count, then bump it
      prev = slot_err_sh[s];
      slot_err_sh[s] = prev + 8'd1;
      if (prev < retry_sh) begin
        slot_sent_sh[s] = 1'b0;
        r = '{ST_RETRY, it.slot, 1'b0};
      end else begin
        slot_busy_sh[s] = 1'b0;
        r = '{ST_FAILED, it.slot, 1'b0};
      end
    end
    return r;
  endfunction

  // picks a busy sent slot (also waiting if want_wait=1); random if none or 1 in 10
  function automatic bit [6:0] pick_slot(input bit want_wait);
    int cand[$];
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_busy_sh[i] && slot_sent_sh[i] && (!want_wait || slot_wait_sh[i]))
        cand.push_back(i);
    end
    if (cand.size() == 0 || $urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  function automatic in_item_t make_item(input int alloc_pct);
    in_item_t it;
    int pick;
    int step;
    it = '0;
    it.slot = 7'($urandom_range(0, 127));
    it.is_write = 1'($urandom);
    it.has_callback = 1'($urandom);
    it.has_delay = 1'($urandom);
    it.now_time = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      it.mode = MODE_ALLOC;
    end else if (pick < alloc_pct + (100 - alloc_pct) * 40 / 100) begin
      it.mode = MODE_TICK;
      step = (timeout_sh > pause_sh ? timeout_sh : pause_sh) / 3 + 20;
      if (step > 5000) step = 5000;
      case ($urandom_range(0, 19))
        0: bus_time = $urandom;
        1: bus_time = bus_time + $urandom_range(0, 200000000);
        2: bus_time = bus_time + 32'(timeout_sh) + 32'(pause_sh);
        default: bus_time = bus_time + $urandom_range(0, step);
      endcase
      it.now_time = bus_time;
    end else if (pick < alloc_pct + (100 - alloc_pct) * 65 / 100) begin
      it.mode = MODE_DONE;
      it.slot = pick_slot(1'b0);
    end else if (pick < alloc_pct + (100 - alloc_pct) * 85 / 100) begin
      it.mode = MODE_FAIL;
      it.slot = pick_slot(1'b0);
    end else if (pick < alloc_pct + (100 - alloc_pct) * 95 / 100) begin
      it.mode = MODE_DELAY;
      it.slot = pick_slot(1'b1);
    end else begin
      // noise: unused modes
      it.mode = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  // one item through the input handshake; valid is kept high across back-to-back items
  task automatic send_item(input in_item_t it, output out_item_t predicted);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    end
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predicted = next_status(it);
    pending_status_q.push_back(predicted);
    burst_left--;
  endtask

  task automatic drain_all();
    @(negedge clk) in_valid <= 1'b0;
    wait (pending_status_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input bit [26:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      CFG_TIMEOUT: timeout_sh = val;
      CFG_PAUSE: pause_sh = val;
      CFG_RETRY: retry_sh = val[7:0];
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_status_q.size() == 0) begin
        report_mismatch("unexpected item, status", out_data.status, -1);
      end else begin
        if (out_data.status !== pending_status_q[0].status)
          report_mismatch("status", out_data.status, pending_status_q[0].status);
        if (out_data.out_slot !== pending_status_q[0].out_slot)
          report_mismatch("out_slot", out_data.out_slot, pending_status_q[0].out_slot);
        if (out_data.out_write !== pending_status_q[0].out_write)
          report_mismatch("out_write", out_data.out_write, pending_status_q[0].out_write);
        void'(pending_status_q.pop_front());
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      out_ready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_ready <= 1'b1;
      if (stall_mode != 0 && $urandom_range(0, 3) == 0)
        stall_cnt <= (stall_mode == 1) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    end
  end

  // run limit
  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    out_item_t got;
    in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TIMEOUT;
    cfg_data = '0;
    err_count = 0;
    burst_left = 0;
    gap_max = 0;
    stall_mode = 0;
    bus_time = 32'd5000;
    timeout_sh = TIMEOUT_RST;
    pause_sh = PAUSE_RST;
    retry_sh = RETRY_RST;
    next_issue_sh = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_busy_sh[i] = 1'b0;
      slot_sent_sh[i] = 1'b0;
      slot_wait_sh[i] = 1'b0;
      slot_wr_sh[i] = 1'b0;
      slot_notify_sh[i] = 1'b0;
      slot_err_sh[i] = '0;
      slot_dl_sh[i] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed table, reset register values
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_item(dir_tab[r].item, got);
      if (dir_tab[r].chk && got !== dir_tab[r].res)
        report_mismatch($sformatf("directed row %0d, status", r), got.status,
                        dir_tab[r].res.status);
    end
    drain_all();

    // random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_TIMEOUT, tmo_set[p]);
      write_reg(CFG_PAUSE, pau_set[p]);
      write_reg(CFG_RETRY, rty_set[p]);
      gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 6 : 30);
      stall_mode = p % 3;
      if (p == 3) bus_time = 32'hFFFF_FE00;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // phase 4 sends mostly allocations for its first 180 items to fill the pool
        it = make_item((p == 4 && n < 180) ? 70 : 18);
        send_item(it, got);
        if (n == ITEMS_PER_PHASE / 2) begin
          // hold off until the block has nothing in flight
          @(negedge clk) in_valid <= 1'b0;
          wait (pending_status_q.size() == 0);
        end
      end
      drain_all();
    end

    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
